[design/telnet_stream_decoder_assert.svh]
// assertion macros for the telnet stream decoder
`ifndef TELNET_STREAM_DECODER_ASSERT_SVH
`define TELNET_STREAM_DECODER_ASSERT_SVH

`ifndef ASSERT_OFF
`define TSD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`define TSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TSD_ASSERT(label, prop, msg)
`define TSD_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

[design/tsd_pkg.sv]
// package with telnet codes, parse modes and result record for the stream decoder
package tsd_pkg;

    localparam logic [7:0] CODE_IAC    = 8'd255;
    localparam logic [7:0] CODE_SE     = 8'd240;
    localparam logic [7:0] CODE_SB     = 8'd250;
    localparam logic [7:0] CODE_WILL   = 8'd251;
    localparam logic [7:0] CODE_DONT   = 8'd254;
    localparam logic [7:0] NAWS_OPTION = 8'd31;
    localparam int         NAWS_LEN    = 5;
    localparam int         Q_DEPTH     = 4;

    localparam logic [2:0] MODE_PLAIN   = 3'd0;
    localparam logic [2:0] MODE_CMD     = 3'd1;
    localparam logic [2:0] MODE_OPT     = 3'd2;
    localparam logic [2:0] MODE_SUB     = 3'd3;
    localparam logic [2:0] MODE_SUB_IAC = 3'd4;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_NAWS = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        logic [15:0] columns;
        logic [15:0] rows;
        logic        run_last;
    } t_result;

    function automatic t_result f_data_result(input logic [7:0] b);
        t_result r;
        r           = '0;
        r.kind      = KIND_DATA;
        r.data_byte = b;
        return r;
    endfunction

endpackage

[design/telnet_stream_decoder.sv]
// telnet stream decoder: iac command parsing, naws extraction, result queue
// results of a byte are written into the result queue and reach the outputs when they come to its head
// throughput: one byte per cycle while the queue has room for two more results; the
// four-entry result queue has a single output port, so two results of one byte leave it one at a time
// reset clears parse mode, payload count and the queue; payload bytes are not reset
module telnet_stream_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_kind,
    output logic [7:0]  o_data_byte,
    output logic [15:0] o_columns,
    output logic [15:0] o_rows,
    output logic        o_run_last
);
    import tsd_pkg::*;

    localparam int QA_W = $clog2(Q_DEPTH);
    localparam int QC_W = $clog2(Q_DEPTH + 1);

    logic [2:0]      r_mode, n_mode;
    logic [2:0]      r_pl_count, n_pl_count;
    logic [7:0]      r_pl_bytes [NAWS_LEN];
    t_result         r_q [Q_DEPTH];
    logic [QA_W-1:0] r_q_wr, r_q_rd;
    logic [QC_W-1:0] r_q_count;

    logic            in_acc, out_acc;
    logic            st0, st1;
    logic [7:0]      v0, v1;
    logic [2:0]      cnt_a, cnt_b;
    logic [1:0]      n_res;
    t_result         res0, res1;
    t_result         head;

    assign in_acc  = i_in_valid && o_in_ready;
    assign out_acc = o_out_valid && i_out_ready;

    // parse step for one byte
    always_comb begin
        n_mode     = r_mode;
        n_pl_count = r_pl_count;
        st0        = 1'b0;
        st1        = 1'b0;
        v0         = i_in_byte;
        v1         = i_in_byte;
        n_res      = 2'd0;
        res0       = '0;
        res1       = '0;
        case (r_mode)
            MODE_CMD: begin
                if (i_in_byte == CODE_IAC) begin
                    res0   = f_data_result(CODE_IAC);
                    n_res  = 2'd1;
                    n_mode = MODE_PLAIN;
                end else if (i_in_byte inside {[CODE_SE:CODE_SB - 8'd1]}) begin
                    n_mode = MODE_PLAIN;
                end else if (i_in_byte inside {[CODE_WILL:CODE_DONT]}) begin
                    n_mode = MODE_OPT;
                end else if (i_in_byte == CODE_SB) begin
                    n_pl_count = 3'd0;
                    n_mode     = MODE_SUB;
                end else begin
                    res0   = f_data_result(CODE_IAC);
                    res1   = f_data_result(i_in_byte);
                    n_res  = 2'd2;
                    n_mode = MODE_PLAIN;
                end
            end
            MODE_OPT: begin
                n_mode = MODE_PLAIN;
            end
            MODE_SUB: begin
                if (i_in_byte == CODE_IAC) begin
                    n_mode = MODE_SUB_IAC;
                end else begin
                    st0 = 1'b1;
                end
            end
            MODE_SUB_IAC: begin
                if (i_in_byte == CODE_SE) begin
                    if (r_pl_count >= 3'(NAWS_LEN) && r_pl_bytes[0] == NAWS_OPTION) begin
                        res0.kind    = KIND_NAWS;
                        res0.columns = {r_pl_bytes[1], r_pl_bytes[2]};
                        res0.rows    = {r_pl_bytes[3], r_pl_bytes[4]};
                        n_res        = 2'd1;
                    end
                    n_mode = MODE_PLAIN;
                end else if (i_in_byte == CODE_IAC) begin
                    st0 = 1'b1;
                    v0  = CODE_IAC;
                end else begin
                    st0    = 1'b1;
                    v0     = CODE_IAC;
                    st1    = 1'b1;
                    n_mode = MODE_SUB;
                end
            end
            default: begin
                if (i_in_byte == CODE_IAC) begin
                    n_mode = MODE_CMD;
                end else begin
                    res0   = f_data_result(i_in_byte);
                    n_res  = 2'd1;
                    n_mode = MODE_PLAIN;
                end
            end
        endcase
        if (n_res == 2'd1) begin
            res0.run_last = 1'b1;
        end
        if (n_res == 2'd2) begin
            res1.run_last = 1'b1;
        end
        // saturating payload count over up to two stores
        cnt_a = (st0 && r_pl_count < 3'(NAWS_LEN)) ? r_pl_count + 3'd1 : r_pl_count;
        cnt_b = (st1 && cnt_a < 3'(NAWS_LEN)) ? cnt_a + 3'd1 : cnt_a;
        if (st0) begin
            n_pl_count = cnt_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_PLAIN;
            r_pl_count <= 3'd0;
        end else if (in_acc) begin
            r_mode     <= n_mode;
            r_pl_count <= n_pl_count;
        end
    end

    // payload store, no reset
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            for (int i = 0; i < NAWS_LEN; i++) begin
                if (st0 && r_pl_count == 3'(i)) begin
                    r_pl_bytes[i] <= v0;
                end
                if (st1 && cnt_a == 3'(i)) begin
                    r_pl_bytes[i] <= v1;
                end
            end
        end
    end

    // result queue
    always_ff @(posedge i_clk) begin
        if (in_acc && n_res != 2'd0) begin
            r_q[r_q_wr] <= res0;
        end
        if (in_acc && n_res == 2'd2) begin
            r_q[r_q_wr + QA_W'(1)] <= res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_wr    <= '0;
            r_q_rd    <= '0;
            r_q_count <= '0;
        end else begin
            if (in_acc) begin
                r_q_wr <= r_q_wr + QA_W'(n_res);
            end
            if (out_acc) begin
                r_q_rd <= r_q_rd + QA_W'(1);
            end
            r_q_count <= r_q_count + (in_acc ? QC_W'(n_res) : QC_W'(0))
                         - (out_acc ? QC_W'(1) : QC_W'(0));
        end
    end

    assign o_in_ready  = (r_q_count <= QC_W'(Q_DEPTH - 2));
    assign o_out_valid = (r_q_count != '0);
    assign head        = r_q[r_q_rd];
    assign o_kind      = head.kind;
    assign o_data_byte = head.data_byte;
    assign o_columns   = head.columns;
    assign o_rows      = head.rows;
    assign o_run_last  = head.run_last;

`include "telnet_stream_decoder_assert.svh"

    `TSD_ASSERT(a_q_bound, r_q_count <= QC_W'(Q_DEPTH), "result queue overflow")
    `TSD_ASSERT(a_pl_bound, r_pl_count <= 3'(NAWS_LEN), "payload count beyond naws length")
    `TSD_ASSERT(a_naws_last, o_out_valid && o_kind |-> o_run_last, "naws report not last")
    `TSD_ASSERT_NEXT(a_sb_start, in_acc && r_mode == MODE_CMD && i_in_byte == CODE_SB, r_mode == MODE_SUB && r_pl_count == 3'd0, "sb did not open payload")
    `TSD_ASSERT_NEXT(a_plain_data, in_acc && r_mode == MODE_PLAIN && i_in_byte != CODE_IAC && r_q_count == '0, o_out_valid && o_data_byte == $past(i_in_byte), "plain byte not queued")

endmodule
